[hw/rtl/kvt_pkg.sv]
package kvt_pkg;

   // Command codes
   localparam logic [1:0] CMD_ADD    = 2'd0;
   localparam logic [1:0] CMD_REMOVE = 2'd1;
   localparam logic [1:0] CMD_FIND   = 2'd2;

   // Status codes
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_MISS = 2'd2;

   typedef struct packed {
      logic [1:0]          cmd;
      logic signed [31:0]  key;
      logic signed [31:0]  value_in;
   } req_type;

   typedef struct packed {
      logic signed [31:0]  value_out;
      logic [1:0]          status;
      logic [4:0]          entries_now;
   } rsp_type;

endpackage

[hw/rtl/kvt_ram.sv]
module kvt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

[hw/rtl/key_value_table_linear.sv]
// Key-value table with linear search, entries kept in insertion order.
// Input channel req_*: one command item (add, remove, find) per handshake;
// an item is taken when req_valid is high and req_stall is low.
// Result channel rsp_*: exactly one result item per command, in order.
// Keys and values sit in two one-port-read RAMs; the search walks the key
// RAM one entry per cycle, and a remove then moves every later entry down
// one place, one entry per cycle through the same read and write ports.
// An add or an unused code needs no search; find and remove scan first.
// The next item can be taken as soon as the result moves into the output
// register; the output register holds the result while rsp_stall is high,
// and the block then takes one more item and waits with its result until
// the register frees.
// Reset empties the table (entry count zero); RAM contents are not cleared
// and need no clearing pass.
module key_value_table_linear #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  kvt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output kvt_pkg::rsp_type rsp_data
);

   localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT,
      S_DONE
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [1:0]         cmd_ff, cmd_in;
   logic [31:0]        key_ff, key_in;
   logic [CNT_W-1:0]   iss_ff, iss_in;
   logic               chk_vld_ff, chk_vld_in;
   logic [CNT_W-1:0]   chk_idx_ff, chk_idx_in;
   logic [CNT_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic               wr_vld_ff, wr_vld_in;
   logic [ADDR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [31:0]        res_value_ff, res_value_in;
   logic [1:0]         res_status_ff, res_status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   kvt_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   logic               ram_wr_en;
   logic [ADDR_W-1:0]  ram_wr_addr;
   logic [31:0]        key_wr_data, value_wr_data;
   logic [ADDR_W-1:0]  ram_rd_addr;
   logic [31:0]        key_rd_data, value_rd_data;
   logic               req_take, out_free, key_hit;
   logic [CNT_W+4:0]   count_ext;

   kvt_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_key_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (key_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (key_rd_data)
   );

   kvt_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_value_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (value_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (value_rd_data)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign key_hit   = chk_vld_ff && (key_rd_data == key_ff);
   assign count_ext = {5'b0, count_ff};

   // Sequencer: accept, search, shift, deliver
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      iss_in        = iss_ff;
      chk_vld_in    = 1'b0;
      chk_idx_in    = chk_idx_ff;
      rd_ptr_in     = rd_ptr_ff;
      wr_vld_in     = 1'b0;
      wr_ptr_in     = wr_ptr_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = wr_ptr_ff;
      key_wr_data   = key_rd_data;
      value_wr_data = value_rd_data;
      ram_rd_addr   = iss_ff[ADDR_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               cmd_in        = req_data.cmd;
               key_in        = req_data.key;
               iss_in        = '0;
               res_value_in  = '0;
               res_status_in = kvt_pkg::ST_OK;
               state_in      = S_DONE;
               case (req_data.cmd)
                  kvt_pkg::CMD_ADD: begin
                     if (count_ff >= CNT_W'(TABLE_DEPTH)) begin
                        res_status_in = kvt_pkg::ST_FULL;
                     end else begin
                        ram_wr_en     = 1'b1;
                        ram_wr_addr   = count_ff[ADDR_W-1:0];
                        key_wr_data   = req_data.key;
                        value_wr_data = req_data.value_in;
                        count_in      = count_ff + 1'b1;
                     end
                  end
                  kvt_pkg::CMD_REMOVE, kvt_pkg::CMD_FIND: begin
                     state_in = S_SCAN;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         // One key read issued per cycle, compared when it returns
         S_SCAN: begin
            if (key_hit) begin
               if (cmd_ff == kvt_pkg::CMD_FIND) begin
                  res_value_in = value_rd_data;
                  state_in     = S_DONE;
               end else begin
                  rd_ptr_in = chk_idx_ff + 1'b1;
                  state_in  = S_SHIFT;
               end
            end else if (iss_ff < count_ff) begin
               chk_vld_in = 1'b1;
               chk_idx_in = iss_ff;
               iss_in     = iss_ff + 1'b1;
            end else if (!chk_vld_ff) begin
               res_status_in = kvt_pkg::ST_MISS;
               state_in      = S_DONE;
            end
         end

         // Read entry n, write it back at n-1 on the next cycle
         S_SHIFT: begin
            ram_rd_addr = rd_ptr_ff[ADDR_W-1:0];
            if (wr_vld_ff) begin
               ram_wr_en = 1'b1;
            end
            if (rd_ptr_ff < count_ff) begin
               wr_vld_in = 1'b1;
               wr_ptr_in = ADDR_W'(rd_ptr_ff - 1'b1);
               rd_ptr_in = rd_ptr_ff + 1'b1;
            end else if (!wr_vld_ff) begin
               count_in = count_ff - 1'b1;
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.value_out   = res_value_ff;
               rsp_data_in.status      = res_status_ff;
               rsp_data_in.entries_now = count_ext[4:0];
               state_in                = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         chk_vld_ff   <= 1'b0;
         wr_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         chk_vld_ff   <= chk_vld_in;
         wr_vld_ff    <= wr_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      iss_ff        <= iss_in;
      chk_idx_ff    <= chk_idx_in;
      rd_ptr_ff     <= rd_ptr_in;
      wr_ptr_ff     <= wr_ptr_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[hw/rtl/kvt_checker.sv]
module kvt_checker #(
   parameter int TABLE_DEPTH = 16
) (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input kvt_pkg::rsp_type rsp_data
);

   localparam logic [31:0] DEPTH_VEC = 32'(TABLE_DEPTH);

   // One item at a time: busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input taken while previous item in progress");

   // A held result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");

   // Full is only reported with the table at its depth
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == kvt_pkg::ST_FULL)
         |-> (rsp_data.entries_now == DEPTH_VEC[4:0]))
      else $error("full status with table not full");

   // Only a successful find carries a value
   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != kvt_pkg::ST_OK) |-> (rsp_data.value_out == 0))
      else $error("nonzero value on failed command");

endmodule

bind key_value_table_linear kvt_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_kvt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

[tb/key_value_table_linear_test.sv]
`timescale 1ns / 1ps

module key_value_table_linear_test;

   localparam int DEPTH = 16;
   localparam int RANDOM_CMDS = 1500;
   localparam int SETTLE_CYCLES = 64;
   localparam int MAX_SHOWN = 10;
   localparam int EXP_SLOTS = 16;

   // cmd code with no operation behind it
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam logic [31:0] KEY_MIN = 32'h8000_0000;
   localparam logic [31:0] KEY_MAX = 32'h7fff_ffff;
   localparam logic [31:0] ALL_ONES = 32'hffff_ffff;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   kvt_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   kvt_pkg::rsp_type rsp_data;

   key_value_table_linear #(
      .TABLE_DEPTH(DEPTH)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Shadow copy of the table
   logic [31:0] shadow_keys [DEPTH];
   logic [31:0] shadow_vals [DEPTH];
   int          shadow_count = 0;

   // Expected results in acceptance order
   kvt_pkg::rsp_type exp_ring [EXP_SLOTS];
   int               exp_wr = 0;
   int               exp_rd = 0;

   int      fault_count = 0;
   bit      send_calm = 1'b0;
   bit      take_calm = 1'b0;

   // Directed commands; reps > 1 adds consecutive keys
   typedef struct {
      kvt_pkg::req_type cmd_item;
      int               reps;
      bit               typed;
      kvt_pkg::rsp_type want;
   } dir_row_type;

   localparam int DIR_ROWS = 21;

   dir_row_type dir_rows [DIR_ROWS] = '{
      // empty table
      '{'{kvt_pkg::CMD_FIND, 32'h0, 32'h0}, 1, 1'b1,
        '{32'h0, kvt_pkg::ST_MISS, 5'd0}},
      '{'{kvt_pkg::CMD_REMOVE, 32'h0, 32'h0}, 1, 1'b1,
        '{32'h0, kvt_pkg::ST_MISS, 5'd0}},
      '{'{CMD_UNUSED, ALL_ONES, ALL_ONES}, 1, 1'b1,
        '{32'h0, kvt_pkg::ST_OK, 5'd0}},
      // extremes, then a duplicate key
      '{'{kvt_pkg::CMD_ADD, KEY_MIN, KEY_MAX}, 1, 1'b1,
        '{32'h0, kvt_pkg::ST_OK, 5'd1}},
      '{'{kvt_pkg::CMD_ADD, KEY_MAX, KEY_MIN}, 1, 1'b1,
        '{32'h0, kvt_pkg::ST_OK, 5'd2}},
      '{'{kvt_pkg::CMD_FIND, KEY_MIN, 32'h0}, 1, 1'b1,
        '{KEY_MAX, kvt_pkg::ST_OK, 5'd2}},
      '{'{kvt_pkg::CMD_ADD, KEY_MIN, ALL_ONES}, 1, 1'b1,
        '{32'h0, kvt_pkg::ST_OK, 5'd3}},
      '{'{kvt_pkg::CMD_FIND, KEY_MIN, 32'h0}, 1, 1'b1,
        '{KEY_MAX, kvt_pkg::ST_OK, 5'd3}},
      '{'{kvt_pkg::CMD_REMOVE, KEY_MIN, 32'h0}, 1, 1'b1,
        '{32'h0, kvt_pkg::ST_OK, 5'd2}},
      '{'{kvt_pkg::CMD_FIND, KEY_MIN, 32'h0}, 1, 1'b0,
        '{32'h0, kvt_pkg::ST_OK, 5'd0}},
      // misses on a partly filled table
      '{'{kvt_pkg::CMD_FIND, 32'h0, 32'h0}, 1, 1'b1,
        '{32'h0, kvt_pkg::ST_MISS, 5'd2}},
      '{'{kvt_pkg::CMD_REMOVE, 32'h1234_5678, 32'h0}, 1, 1'b1,
        '{32'h0, kvt_pkg::ST_MISS, 5'd2}},
      // fill up, then add to a full table
      '{'{kvt_pkg::CMD_ADD, 32'h100, 32'h5a5a_0000}, 14, 1'b0,
        '{32'h0, kvt_pkg::ST_OK, 5'd0}},
      '{'{kvt_pkg::CMD_ADD, 32'h0, 32'h0}, 1, 1'b1,
        '{32'h0, kvt_pkg::ST_FULL, 5'd16}},
      // last and first entries of a full table
      '{'{kvt_pkg::CMD_FIND, 32'h10d, 32'h0}, 1, 1'b0,
        '{32'h0, kvt_pkg::ST_OK, 5'd0}},
      '{'{kvt_pkg::CMD_REMOVE, 32'h10d, 32'h0}, 1, 1'b0,
        '{32'h0, kvt_pkg::ST_OK, 5'd0}},
      '{'{kvt_pkg::CMD_REMOVE, KEY_MAX, 32'h0}, 1, 1'b0,
        '{32'h0, kvt_pkg::ST_OK, 5'd0}},
      '{'{kvt_pkg::CMD_FIND, KEY_MIN, 32'h0}, 1, 1'b0,
        '{32'h0, kvt_pkg::ST_OK, 5'd0}},
      '{'{CMD_UNUSED, 32'h0, 32'h0}, 1, 1'b0,
        '{32'h0, kvt_pkg::ST_OK, 5'd0}},
      '{'{kvt_pkg::CMD_ADD, 32'h0, 32'h0}, 1, 1'b0,
        '{32'h0, kvt_pkg::ST_OK, 5'd0}},
      '{'{kvt_pkg::CMD_FIND, 32'h0, 32'h0}, 1, 1'b0,
        '{32'h0, kvt_pkg::ST_OK, 5'd0}}
   };

   // Clock
   initial begin
      forever #6 clock = ~clock;
   end

   // Run limit
   initial begin
      #10_000_000;
      $display("** key_value_table_linear: FAILED **");
      $finish;
   end

   // Apply one command to the shadow table and return its result
   function automatic kvt_pkg::rsp_type table_apply(input kvt_pkg::req_type c);
      kvt_pkg::rsp_type r;
      int               hit;
      r = '0;
      r.status = kvt_pkg::ST_OK;
      hit = shadow_count;
      for (int i = shadow_count - 1; i >= 0; i--) begin
         if (shadow_keys[i] == c.key) hit = i;
      end
      case (c.cmd)
         kvt_pkg::CMD_ADD: begin
            if (shadow_count >= DEPTH) begin
               r.status = kvt_pkg::ST_FULL;
            end else begin
               shadow_keys[shadow_count] = c.key;
               shadow_vals[shadow_count] = c.value_in;
               shadow_count++;
            end
         end
         kvt_pkg::CMD_REMOVE: begin
            if (hit == shadow_count) begin
               r.status = kvt_pkg::ST_MISS;
            end else begin
               for (int i = hit; i < shadow_count - 1; i++) begin
                  shadow_keys[i] = shadow_keys[i + 1];
                  shadow_vals[i] = shadow_vals[i + 1];
               end
               shadow_count--;
            end
         end
         kvt_pkg::CMD_FIND: begin
            if (hit == shadow_count) r.status = kvt_pkg::ST_MISS;
            else r.value_out = shadow_vals[hit];
         end
         default: ;
      endcase
      r.entries_now = 5'(shadow_count);
      return r;
   endfunction

   // Drive one command and log its expected result on acceptance
   task automatic send_cmd(input kvt_pkg::req_type item, input bit typed,
                           input kvt_pkg::rsp_type typed_rsp);
      int               gap;
      kvt_pkg::rsp_type predicted;
      gap = send_calm ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
      predicted = table_apply(item);
      exp_ring[exp_wr % EXP_SLOTS] = typed ? typed_rsp : predicted;
      exp_wr++;
      if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
   endtask

   task automatic report_fault(input string what, input kvt_pkg::rsp_type want,
                               input kvt_pkg::rsp_type got);
      fault_count++;
      if (fault_count <= MAX_SHOWN) begin
         $display("%0t: %s: expected value %h status %0d count %0d,",
                  $realtime, what, want.value_out, want.status, want.entries_now);
         $display("   got value %h status %0d count %0d",
                  got.value_out, got.status, got.entries_now);
      end
   endtask

   // Result stall: random hold before each result, with calm stretches
   initial begin : rsp_stall_gen
      int hold;
      @(posedge clock);
      forever begin
         hold = take_calm ? 0 : $urandom_range(0, 16);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         if ($urandom_range(0, 39) == 0) take_calm = !take_calm;
      end
   end

   // Result check against the oldest expectation
   always @(posedge clock) begin : rsp_check
      kvt_pkg::rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (exp_wr == exp_rd) begin
            report_fault("result with no command pending", '0, rsp_data);
         end else begin
            want = exp_ring[exp_rd % EXP_SLOTS];
            exp_rd++;
            if (rsp_data.value_out !== want.value_out || rsp_data.status !== want.status ||
                rsp_data.entries_now !== want.entries_now) begin
               report_fault("result mismatch", want, rsp_data);
            end
         end
      end
   end

   // Stimulus
   initial begin : stimulus
      kvt_pkg::req_type item;
      int               sent;
      int               roll;
      bit               filling;
      logic [31:0]      key_pool [8];

      key_pool = '{32'h0, 32'h1, ALL_ONES, KEY_MIN, KEY_MAX, 32'h5, 32'h6, 32'h7};
      sent = 0;
      filling = 1'b1;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (int n = 0; n < DIR_ROWS; n++) begin
         for (int k = 0; k < dir_rows[n].reps; k++) begin
            item = dir_rows[n].cmd_item;
            item.key = item.key + k;
            item.value_in = item.value_in ^ k;
            send_cmd(item, dir_rows[n].typed, dir_rows[n].want);
         end
      end

      // random commands; the table swings between full and empty
      while (sent < RANDOM_CMDS) begin
         roll = $urandom_range(0, 99);
         if (filling) begin
            item.cmd = roll < 55 ? kvt_pkg::CMD_ADD : roll < 75 ? kvt_pkg::CMD_REMOVE :
                       roll < 96 ? kvt_pkg::CMD_FIND : CMD_UNUSED;
         end else begin
            item.cmd = roll < 20 ? kvt_pkg::CMD_ADD : roll < 65 ? kvt_pkg::CMD_REMOVE :
                       roll < 96 ? kvt_pkg::CMD_FIND : CMD_UNUSED;
         end
         // mostly keys held in the table, some from a fixed pool, some fully random
         roll = $urandom_range(0, 99);
         if (shadow_count > 0 && roll < 60) begin
            item.key = shadow_keys[$urandom_range(0, shadow_count - 1)];
         end else if (roll < 85) begin
            item.key = key_pool[$urandom_range(0, 7)];
         end else begin
            item.key = $urandom;
         end
         item.value_in = $urandom;
         send_cmd(item, 1'b0, '0);
         if (item.cmd != CMD_UNUSED) sent++;
         if ((filling && shadow_count == DEPTH && $urandom_range(0, 3) == 0) ||
             (!filling && shadow_count == 0) || $urandom_range(0, 59) == 0) begin
            filling = !filling;
         end
      end

      req_valid <= 1'b0;
      while (exp_wr != exp_rd) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (fault_count == 0 && exp_wr == exp_rd) begin
         $display("** key_value_table_linear: PASSED **");
      end else begin
         $display("** key_value_table_linear: FAILED **");
      end
      $finish;
   end

endmodule
